// ===== rtl/pse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and sizes for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int VAR_COUNT_DEF   = 32;

	localparam logic [31:0] UNDEF_ROW = 32'h8000_0001;

	localparam logic [2:0] REQ_LIT  = 3'd0;
	localparam logic [2:0] REQ_VAR  = 3'd1;
	localparam logic [2:0] REQ_OP   = 3'd2;
	localparam logic [2:0] REQ_GOTO = 3'd3;
	localparam logic [2:0] REQ_EOL  = 3'd4;

	typedef enum logic [2:0] {
		K_LIT, K_VAR, K_OP, K_GOTO, K_EOL
	} kind_t;

	typedef enum logic [4:0] {
		OP_ASSIGN, OP_LOR, OP_LAND, OP_BOR, OP_XOR, OP_BAND, OP_EQ, OP_NEQ,
		OP_SHL, OP_SHR, OP_LEQ, OP_LT, OP_GEQ, OP_GT, OP_ADD, OP_SUB,
		OP_MUL, OP_DIV, OP_MOD
	} op_t;

	typedef enum logic [2:0] {
		ST_OK, ST_GOTO, ST_EMPTY, ST_UNDER, ST_OVER, ST_DIVZ, ST_NONVAR
	} status_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_OP1, S_OP2, S_OP3, S_MUL, S_DIV, S_EOL1, S_EOL2
	} state_t;

	// token after classification; value holds literal, variable index or goto row
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		op_t         op;
		logic [16:0] nrow;
	} item_t;

	typedef struct packed {
		logic        is_var;
		logic [31:0] val;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/pse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_req_if / pse_rsp_if
// Token and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pse_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic signed [31:0] literal_value;
	logic [4:0]  var_index;
	logic [4:0]  op_code;
	logic [15:0] current_row;

	modport source (output valid, req_type, literal_value, var_index, op_code,
		current_row, input ready);
	modport sink (input valid, req_type, literal_value, var_index, op_code,
		current_row, output ready);
endinterface

interface pse_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] result_value;
	logic signed [31:0] next_row;
	logic [2:0]  status;

	modport source (output valid, result_value, next_row, status, input ready);
	modport sink (input valid, result_value, next_row, status, output ready);
endinterface

// ===== rtl/postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix token evaluator with operand stack and variable file.
//
//   channel  dir  word
//   req      in   one token: type, literal, variable index, operator, row
//   rsp      out  one line result: value, next row, status
//
// pushes, gotos and ends of empty lines are done in the idle state, an end
// of line passes EOL1 and EOL2, operators pass OP1, OP2 and OP3, mul then
// MUL and div/mod then DIV, waiting on the bit-serial divider. after reset
// the variable file is cleared, one entry per cycle, before tokens execute.
// a two-entry queue decouples token intake from execution; execution
// waits while an earlier result sits untaken in the output register.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int VAR_COUNT   = pse_pkg::VAR_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	pse_req_if.sink  req,
	pse_rsp_if.source rsp
);
	import pse_pkg::*;

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	pse_front #(
		.VAR_COUNT (VAR_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	pse_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.VAR_COUNT   (VAR_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

// ===== rtl/pse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_front
// Accepts tokens, drops unknown ones, decodes and queues them (two entries).
// ----------------------------------------------------------------------------
module pse_front #(
	parameter int VAR_COUNT = pse_pkg::VAR_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	pse_req_if.sink         req,
	output logic            q_valid,
	output pse_pkg::item_t  q_item,
	input  logic            q_pop
);
	import pse_pkg::*;

	localparam int VIW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	logic [VIW-1:0] mod_tbl [32];
	item_t          dec;
	logic           keep;
	logic           push;
	item_t          mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	for (genvar g = 0; g < 32; g++) begin : g_mod
		localparam int M = g % VAR_COUNT;
		assign mod_tbl[g] = VIW'(M);
	end

	always_comb begin
		keep      = 1'b1;
		dec.kind  = K_LIT;
		dec.value = req.literal_value;
		dec.op    = op_t'(req.op_code);
		dec.nrow  = 17'(req.current_row) + 17'd1;
		case (req.req_type)
			REQ_LIT: dec.kind = K_LIT;
			REQ_VAR: begin
				dec.kind  = K_VAR;
				dec.value = 32'(mod_tbl[req.var_index]);
			end
			REQ_OP: begin
				dec.kind = K_OP;
				keep     = (req.op_code <= 5'(OP_MOD));
			end
			REQ_GOTO: begin
				dec.kind  = K_GOTO;
				dec.value = req.literal_value[31] ? UNDEF_ROW : req.literal_value;
			end
			REQ_EOL: dec.kind = K_EOL;
			default: keep = 1'b0;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready && keep;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ===== rtl/pse_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_div
// Signed 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pse_pkg::div_req_t dreq,
	output pse_pkg::div_rsp_t drsp
);
	import pse_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic        sa_q;
	logic [32:0] shifted;
	logic [32:0] trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			rem_q <= '0;
			quo_q <= dreq.a[31] ? -dreq.a : dreq.a;
			den_q <= dreq.b[31] ? -dreq.b : dreq.b;
			neg_q <= dreq.a[31] ^ dreq.b[31];
			sa_q  <= dreq.a[31];
		end else if (busy_q) begin
			rem_q <= trial[32] ? shifted[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ~trial[32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign drsp.busy = busy_q;
	assign drsp.done = done_q;
	assign drsp.quo  = neg_q ? -quo_q : quo_q;
	assign drsp.rem  = sa_q ? -rem_q : rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !busy_q)
		else $error("divider started while busy");

endmodule

// ===== rtl/pse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_back
// Executes queued tokens on the operand stack and variable file.
// ----------------------------------------------------------------------------
module pse_back #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int VAR_COUNT   = pse_pkg::VAR_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  pse_pkg::item_t q_item,
	output logic           q_pop,
	pse_rsp_if.source      rsp
);
	import pse_pkg::*;

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int VIW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	state_t      state_q, state_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic        skip_q, skip_nxt;

	entry_t      stk_mem [STACK_DEPTH];
	entry_t      stk_rd_q;
	logic        stk_we;
	logic [AW-1:0] stk_waddr, stk_raddr;
	entry_t      stk_wdata;

	logic [31:0] var_mem [VAR_COUNT];
	logic [31:0] var_rd_q;
	logic        var_we;
	logic [VIW-1:0] var_waddr, var_raddr;
	logic [31:0] var_wdata;
	logic [VIW-1:0] clr_q;

	entry_t      re_q, le_q;
	logic [31:0] r_q;
	op_t         op_q;
	logic [16:0] nrow_q;
	logic [31:0] mul_q;
	logic        is_mod_q;

	logic [CW-1:0] cnt_m1, cnt_m2;
	logic [31:0] lv;
	logic [31:0] alu;
	logic        out_free;
	logic        emit;
	logic [31:0] emit_val, emit_row;
	status_t     emit_st;
	logic        out_valid_q;
	logic [31:0] out_val_q, out_row_q;
	status_t     out_st_q;

	div_req_t    dreq;
	div_rsp_t    drsp;

	pse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign out_free = !out_valid_q || rsp.ready;
	assign lv       = le_q.is_var ? var_rd_q : le_q.val;

	always_comb begin
		case (op_q)
			OP_LOR:  alu = 32'((lv != 0) || (r_q != 0));
			OP_LAND: alu = 32'((lv != 0) && (r_q != 0));
			OP_BOR:  alu = lv | r_q;
			OP_XOR:  alu = lv ^ r_q;
			OP_BAND: alu = lv & r_q;
			OP_EQ:   alu = 32'(lv == r_q);
			OP_NEQ:  alu = 32'(lv != r_q);
			OP_SHL:  alu = lv << r_q[4:0];
			OP_SHR:  alu = $signed(lv) >>> r_q[4:0];
			OP_LEQ:  alu = 32'($signed(lv) <= $signed(r_q));
			OP_LT:   alu = 32'($signed(lv) < $signed(r_q));
			OP_GEQ:  alu = 32'($signed(lv) >= $signed(r_q));
			OP_GT:   alu = 32'($signed(lv) > $signed(r_q));
			OP_ADD:  alu = lv + r_q;
			OP_SUB:  alu = lv - r_q;
			default: alu = r_q;
		endcase
	end

	always_comb begin
		state_nxt  = state_q;
		count_nxt  = count_q;
		skip_nxt   = skip_q;
		q_pop      = 1'b0;
		stk_we     = 1'b0;
		stk_waddr  = count_q[AW-1:0];
		stk_wdata  = '{is_var: 1'b0, val: alu};
		stk_raddr  = cnt_m1[AW-1:0];
		var_we     = 1'b0;
		var_waddr  = clr_q;
		var_wdata  = '0;
		var_raddr  = stk_rd_q.val[VIW-1:0];
		emit       = 1'b0;
		emit_val   = '0;
		emit_row   = 32'(nrow_q);
		emit_st    = ST_OK;
		dreq.start = 1'b0;
		dreq.a     = lv;
		dreq.b     = r_q;
		case (state_q)
			S_CLR: begin
				var_we = 1'b1;
				if (clr_q == VIW'(VAR_COUNT - 1))
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				emit_row = 32'(q_item.nrow);
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (skip_q) begin
						if (q_item.kind == K_EOL)
							skip_nxt = 1'b0;
					end else begin
						case (q_item.kind)
							K_LIT, K_VAR: begin
								if (count_q == CW'(STACK_DEPTH)) begin
									emit      = 1'b1;
									emit_st   = ST_OVER;
									count_nxt = '0;
									skip_nxt  = 1'b1;
								end else begin
									stk_we    = 1'b1;
									stk_wdata = '{is_var: (q_item.kind == K_VAR),
										val: q_item.value};
									count_nxt = count_q + CW'(1);
								end
							end
							K_OP: begin
								if (count_q < CW'(2)) begin
									emit      = 1'b1;
									emit_st   = ST_UNDER;
									count_nxt = '0;
									skip_nxt  = 1'b1;
								end else begin
									state_nxt = S_OP1;
								end
							end
							K_GOTO: begin
								emit      = 1'b1;
								emit_st   = ST_GOTO;
								emit_row  = q_item.value;
								count_nxt = '0;
								skip_nxt  = 1'b1;
							end
							K_EOL: begin
								if (count_q == '0) begin
									emit    = 1'b1;
									emit_st = ST_EMPTY;
								end else begin
									state_nxt = S_EOL1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			S_OP1: begin
				stk_raddr = cnt_m2[AW-1:0];
				state_nxt = S_OP2;
			end
			S_OP2: begin
				state_nxt = S_OP3;
			end
			S_OP3: begin
				stk_waddr = cnt_m2[AW-1:0];
				var_waddr = le_q.val[VIW-1:0];
				var_wdata = r_q;
				case (op_q)
					OP_ASSIGN: begin
						if (!le_q.is_var) begin
							emit      = 1'b1;
							emit_st   = ST_NONVAR;
							count_nxt = '0;
							skip_nxt  = 1'b1;
						end else begin
							var_we    = 1'b1;
							stk_we    = 1'b1;
							count_nxt = cnt_m1;
						end
						state_nxt = S_IDLE;
					end
					OP_MUL: state_nxt = S_MUL;
					OP_DIV, OP_MOD: begin
						if (r_q == '0) begin
							emit      = 1'b1;
							emit_st   = ST_DIVZ;
							count_nxt = '0;
							skip_nxt  = 1'b1;
							state_nxt = S_IDLE;
						end else begin
							dreq.start = 1'b1;
							state_nxt  = S_DIV;
						end
					end
					default: begin
						stk_we    = 1'b1;
						count_nxt = cnt_m1;
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_MUL: begin
				stk_waddr = cnt_m2[AW-1:0];
				stk_we    = 1'b1;
				stk_wdata = '{is_var: 1'b0, val: mul_q};
				count_nxt = cnt_m1;
				state_nxt = S_IDLE;
			end
			S_DIV: begin
				stk_waddr = cnt_m2[AW-1:0];
				stk_wdata = '{is_var: 1'b0, val: is_mod_q ? drsp.rem : drsp.quo};
				if (drsp.done) begin
					stk_we    = 1'b1;
					count_nxt = cnt_m1;
					state_nxt = S_IDLE;
				end
			end
			S_EOL1: begin
				state_nxt = S_EOL2;
			end
			S_EOL2: begin
				emit      = 1'b1;
				emit_st   = ST_OK;
				emit_val  = re_q.is_var ? var_rd_q : re_q.val;
				count_nxt = '0;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_waddr] <= stk_wdata;
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk) begin
		if (var_we)
			var_mem[var_waddr] <= var_wdata;
		var_rd_q <= var_mem[var_raddr];
	end

	// operand holding registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q   <= q_item.op;
			nrow_q <= q_item.nrow;
		end
		if (state_q == S_OP1 || state_q == S_EOL1)
			re_q <= stk_rd_q;
		if (state_q == S_OP2) begin
			le_q <= stk_rd_q;
			r_q  <= re_q.is_var ? var_rd_q : re_q.val;
		end
		if (state_q == S_OP3) begin
			mul_q    <= lv * r_q;
			is_mod_q <= (op_q == OP_MOD);
		end
		if (emit) begin
			out_val_q <= emit_val;
			out_row_q <= emit_row;
			out_st_q  <= emit_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			count_q     <= '0;
			skip_q      <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			skip_q  <= skip_nxt;
			if (state_q == S_CLR)
				clr_q <= clr_q + VIW'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_val_q;
	assign rsp.next_row     = out_row_q;
	assign rsp.status       = out_st_q;

	a_skip_empty: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> count_q == '0)
		else $error("stack not empty while skipping");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> drsp.busy || drsp.done)
		else $error("waiting on idle divider");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwritten before taken");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the postfix stack evaluator: directed token lines cover
// every operator, the error statuses, gotos and skipping; random lines follow
// under three idling profiles and one long receiver hold-off. Every result
// word is checked against an in-bench model of stack and variable file.
// ----------------------------------------------------------------------------
module tb_top;
	import pse_pkg::*;

	localparam int DEPTH = 16;
	localparam int NVARS = 32;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [31:0] value;
		logic [31:0] row;
		logic [2:0]  status;
	} line_result_t;

	logic clk;
	logic arst_n;
	pse_req_if req ();
	pse_rsp_if rsp ();

	postfix_stack_evaluator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// model state
	logic [32:0] mstack [DEPTH];
	int unsigned mcount;
	logic [31:0] mvars [NVARS];
	bit mskip;

	line_result_t pending_lines [$];
	int errors = 0;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_rx;
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("postfix_stack_evaluator regression: fail");
			$finish;
		end
	end

	function automatic void queue_line(line_result_t lr);
		pending_lines.insert(pending_lines.size(), lr);
	endfunction

	function automatic logic [31:0] read_entry(logic [32:0] e);
		if (e[32])
			return mvars[e[4:0]];
		return e[31:0];
	endfunction

	function automatic void fail_line(logic [31:0] row, status_t st);
		mcount = 0;
		mskip = 1'b1;
		queue_line('{32'd0, row, st});
	endfunction

	// apply one token to the model, queueing the line result it produces
	function automatic void evaluate_token(logic [2:0] kind, logic [31:0] lit,
		logic [4:0] vidx, logic [4:0] opc, logic [15:0] crow);
		logic [31:0] nxt;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] v;
		logic [32:0] le;
		logic signed [31:0] sl;
		logic signed [31:0] sr;
		nxt = {16'd0, crow} + 32'd1;
		v = '0;
		if (mskip) begin
			if (kind == REQ_EOL)
				mskip = 1'b0;
			return;
		end
		case (kind)
			REQ_LIT, REQ_VAR: begin
				if (mcount >= DEPTH) begin
					fail_line(nxt, ST_OVER);
					return;
				end
				mstack[mcount] = (kind == REQ_LIT) ? {1'b0, lit} : {1'b1, 27'd0, vidx};
				mcount++;
			end
			REQ_OP: begin
				if (opc > OP_MOD)
					return;
				if (mcount < 2) begin
					fail_line(nxt, ST_UNDER);
					return;
				end
				r = read_entry(mstack[mcount - 1]);
				le = mstack[mcount - 2];
				mcount -= 2;
				l = read_entry(le);
				sl = l;
				sr = r;
				case (op_t'(opc))
					OP_ASSIGN: begin
						if (!le[32]) begin
							fail_line(nxt, ST_NONVAR);
							return;
						end
						mvars[le[4:0]] = r;
						v = r;
					end
					OP_LOR: v = 32'(l != 0 || r != 0);
					OP_LAND: v = 32'(l != 0 && r != 0);
					OP_BOR: v = l | r;
					OP_XOR: v = l ^ r;
					OP_BAND: v = l & r;
					OP_EQ: v = 32'(l == r);
					OP_NEQ: v = 32'(l != r);
					OP_SHL: v = l << r[4:0];
					OP_SHR: v = sl >>> r[4:0];
					OP_LEQ: v = 32'(sl <= sr);
					OP_LT: v = 32'(sl < sr);
					OP_GEQ: v = 32'(sl >= sr);
					OP_GT: v = 32'(sl > sr);
					OP_ADD: v = l + r;
					OP_SUB: v = l - r;
					OP_MUL: v = l * r;
					default: begin
						if (r == 0) begin
							fail_line(nxt, ST_DIVZ);
							return;
						end
						if (sl == 32'sh8000_0000 && sr == -32'sd1)
							v = (opc == OP_DIV) ? 32'h8000_0000 : 32'd0;
						else
							v = (opc == OP_DIV) ? sl / sr : sl % sr;
					end
				endcase
				mstack[mcount] = {1'b0, v};
				mcount++;
			end
			REQ_GOTO: begin
				mcount = 0;
				mskip = 1'b1;
				queue_line('{32'd0, lit[31] ? UNDEF_ROW : lit, ST_GOTO});
			end
			REQ_EOL: begin
				if (mcount == 0) begin
					queue_line('{32'd0, nxt, ST_EMPTY});
				end else begin
					v = read_entry(mstack[mcount - 1]);
					mcount = 0;
					queue_line('{v, nxt, ST_OK});
				end
			end
			default: ;
		endcase
	endfunction

	// result checker and receiver idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_lines.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word %h %h %0d", rsp.result_value,
							rsp.next_row, rsp.status);
				end else begin
					line_result_t exp_line;
					exp_line = pending_lines.pop_front();
					if (rsp.result_value !== exp_line.value || rsp.next_row !== exp_line.row
						|| rsp.status !== exp_line.status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %h %h %0d got %h %h %0d", exp_line.value,
								exp_line.row, exp_line.status, rsp.result_value,
								rsp.next_row, rsp.status);
					end
				end
			end
			rsp.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_token(logic [2:0] kind, logic [31:0] lit = 0,
		logic [4:0] vidx = 0, logic [4:0] opc = 0, logic [15:0] crow = 0);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.literal_value <= lit;
		req.var_index <= vidx;
		req.op_code <= opc;
		req.current_row <= crow;
		do @(posedge clk); while (!req.ready);
		evaluate_token(kind, lit, vidx, opc, crow);
	endtask

	task automatic wait_drained();
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_operators();
		for (int o = 0; o <= OP_MOD; o++) begin
			send_token(REQ_LIT, 32'h8000_0000);
			send_token(REQ_LIT, (o == OP_DIV || o == OP_MOD) ? 32'hffff_ffff : 32'd33);
			send_token(REQ_OP, 0, 0, 5'(o));
			send_token(REQ_EOL, 0, 0, 0, 16'(o));
		end
	endtask

	task automatic test_special_lines();
		send_token(REQ_VAR, 0, 5'd31);
		send_token(REQ_LIT, 32'h7fff_ffff);
		send_token(REQ_OP, 0, 0, OP_ASSIGN);
		send_token(REQ_VAR, 0, 5'd31);
		send_token(REQ_EOL, 0, 0, 0, 16'hffff);
		send_token(REQ_EOL, 0, 0, 0, 16'd7);
		send_token(REQ_OP, 0, 0, OP_ADD);
		send_token(REQ_LIT, 5);
		send_token(REQ_EOL);
		send_token(REQ_LIT, 5);
		send_token(REQ_LIT, 0);
		send_token(REQ_OP, 0, 0, OP_MOD);
		send_token(REQ_EOL);
		send_token(REQ_LIT, 1);
		send_token(REQ_LIT, 2);
		send_token(REQ_OP, 0, 0, OP_ASSIGN);
		send_token(REQ_EOL);
		for (int k = 0; k <= DEPTH; k++)
			send_token(REQ_LIT, k);
		send_token(REQ_EOL);
		send_token(REQ_GOTO, 32'hffff_fff0);
		send_token(REQ_LIT, 1);
		send_token(REQ_EOL);
		send_token(REQ_GOTO, 32'd65536);
		send_token(REQ_EOL);
		send_token(REQ_OP, 0, 0, 5'd31);
		send_token(3'd7, 32'hffff_ffff, 5'd31, 5'd31, 16'hffff);
		send_token(REQ_EOL);
	endtask

	// mostly well-formed lines, with some noise and broken lines
	task automatic random_lines(int tokens);
		int sent;
		int depth;
		sent = 0;
		while (sent < tokens) begin
			depth = 0;
			repeat ($urandom_range(8)) begin
				int pick;
				pick = $urandom_range(99);
				if (pick < 4)
					send_token(3'($urandom_range(7)), $urandom, 5'($urandom),
						5'($urandom), 16'($urandom));
				else if (depth >= 2 && pick < 50) begin
					send_token(REQ_OP, 0, 0, 5'($urandom_range(pick < 8 ? 31 : 18)));
					depth--;
				end else if (pick < 75) begin
					send_token(REQ_LIT, rand_operand());
					depth++;
				end else begin
					send_token(REQ_VAR, 0, 5'($urandom));
					depth++;
				end
				sent++;
			end
			if ($urandom_range(9) == 0)
				send_token(REQ_GOTO, $urandom, 0, 0, 16'($urandom));
			send_token(REQ_EOL, 0, 0, 0, 16'($urandom));
			sent++;
		end
	endtask

	task automatic test_backpressure();
		hold_rx = 1'b1;
		fork
			begin
				random_lines(40);
				req.valid <= 1'b0;
			end
			begin
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end
		join
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = '0;
		req.literal_value = '0;
		req.var_index = '0;
		req.op_code = '0;
		req.current_row = '0;
		hold_rx = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		mcount = 0;
		mskip = 1'b0;
		foreach (mvars[k])
			mvars[k] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_special_lines();
		send_idle_pct = 38;
		recv_idle_pct = 75;
		random_lines(130);
		send_idle_pct = 75;
		recv_idle_pct = 38;
		random_lines(130);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_lines(130);
		test_backpressure();
		wait_drained();
		if (errors == 0)
			$display("postfix_stack_evaluator regression: pass");
		else
			$display("postfix_stack_evaluator regression: fail");
		$finish;
	end
endmodule
